[sv/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared sizes, codes, types and helper functions of the block bitmap
// allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   // Blocks the bitmap can hold. The 12-bit index fields address 4096 blocks at most.
   localparam int NUM_BLOCKS = 4096;
   localparam int INDEX_W    = 12;
   localparam int COUNT_W    = 13;
   localparam int INDEX_SPAN = 1 << INDEX_W;
   localparam int MAP_BLOCKS = (NUM_BLOCKS < INDEX_SPAN) ? NUM_BLOCKS : INDEX_SPAN;

   // Bitmap row geometry: one memory row holds WORD_W bits.
   localparam int WORD_W = (MAP_BLOCKS < 32) ? MAP_BLOCKS : 32;
   localparam int BIT_W  = $clog2(WORD_W);
   localparam int ROWS   = MAP_BLOCKS / WORD_W;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Operation codes
   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_FREE  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_INIT  = 2'd3;

   // Result status codes
   localparam logic [1:0] STS_OK     = 2'd0;
   localparam logic [1:0] STS_NOFREE = 2'd1;
   localparam logic [1:0] STS_RANGE  = 2'd2;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED = 1'b1;

   // Access bundle toward the bitmap store
   typedef struct packed {
      logic              rd_en;
      logic [ROW_W-1:0]  rd_row;
      logic              wr_en;
      logic [ROW_W-1:0]  wr_row;
      logic [WORD_W-1:0] wr_data;
   } map_req_type;

   function automatic logic [ROW_W-1:0] row_of(input logic [INDEX_W-1:0] idx);
      logic [INDEX_W-1:0] t;
      t = idx >> BIT_W;
      return t[ROW_W-1:0];
   endfunction

   function automatic logic [BIT_W-1:0] bit_of(input logic [INDEX_W-1:0] idx);
      return idx[BIT_W-1:0];
   endfunction

   // Position of the lowest clear bit; zero when none is clear.
   function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (!w[b]) begin
            pos = BIT_W'(b);
         end
      end
      return pos;
   endfunction

endpackage

[sv/bba_req_if.sv]
// ----------------------------------------------------------------------------
// bba_req_if
// Request channel of the block bitmap allocator: action and block index.
// ----------------------------------------------------------------------------
interface bba_req_if;
   import bba_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [INDEX_W-1:0] block_index;

   modport source (output valid, output action, output block_index, input ready);
   modport sink   (input valid, input action, input block_index, output ready);
endinterface

[sv/bba_rsp_if.sv]
// ----------------------------------------------------------------------------
// bba_rsp_if
// Response channel of the block bitmap allocator: one result per request.
// ----------------------------------------------------------------------------
interface bba_rsp_if;
   import bba_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] result_index;
   logic               bit_value;
   logic [COUNT_W-1:0] free_count;
   logic [1:0]         status;

   modport source (output valid, output result_index, output bit_value,
                   output free_count, output status, input ready);
   modport sink   (input valid, input result_index, input bit_value,
                   input free_count, input status, output ready);
endinterface

[sv/block_bitmap_allocator_top.sv]
// ----------------------------------------------------------------------------
// block_bitmap_allocator_top
// First-fit block allocator over a used/free bitmap with a free-block count.
// ----------------------------------------------------------------------------
// The bitmap lives in a 128 x 32 memory with a registered read; rows never
// written since reset read as free through per-row valid bits, so no clearing
// pass follows reset. One request is worked at a time. Free and read go
// through a row read, a modify/write or bit pick, and a result stage.
// Allocate walks the rows from row 0 at one row per cycle until it meets a
// free bit inside the managed span or ends on its last row, inspecting 1 to
// 128 rows. Initialize rewrites every row. A refused allocate (count zero or
// empty span) and an out-of-range free or read go straight to the result
// stage. A new request is taken while a previous response still waits on
// the response channel. Configuration writes take effect on the next
// request; write them only while idle.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_top (
   input  logic                          clock,
   input  logic                          reset,
   bba_req_if.sink                       req_ch,
   bba_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [bba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bba_pkg::COUNT_W-1:0]   csr_wr_data
);
   import bba_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_FREE = 6'b000100,
      ST_READ = 6'b001000,
      ST_INIT = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   typedef struct packed {
      logic [INDEX_W-1:0] result_index;
      logic               bit_value;
      logic [COUNT_W-1:0] free_count;
      logic [1:0]         status;
   } rsp_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] free_ff, free_in;
   logic [COUNT_W-1:0] total_ff;
   logic [COUNT_W-1:0] rsv_cfg_ff;
   logic [COUNT_W-1:0] rsv_ff, rsv_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;

   map_req_type        map_req;
   logic [WORD_W-1:0]  map_rd_data;

   // Managed span and its last row
   logic [COUNT_W-1:0] span;
   logic [COUNT_W-1:0] span_m1;
   logic [ROW_W-1:0]   last_row;
   logic [WORD_W-1:0]  tail_mask;
   logic [WORD_W-1:0]  scan_word;
   logic [WORD_W-1:0]  init_word;
   logic [COUNT_W:0]   init_base;
   logic [COUNT_W:0]   init_diff;
   logic               req_fire;
   logic               out_free;
   logic               idx_in_span;

   bba_map u_map (
      .clock   (clock),
      .reset   (reset),
      .map_req (map_req),
      .rd_data (map_rd_data)
   );

   assign span     = (total_ff > COUNT_W'(MAP_BLOCKS)) ? COUNT_W'(MAP_BLOCKS) : total_ff;
   assign span_m1  = span - COUNT_W'(1);
   assign last_row = row_of(span_m1[INDEX_W-1:0]);

   // Bits of the last row that lie at or above the span count as used
   always_comb begin
      for (int b = 0; b < WORD_W; b++) begin
         tail_mask[b] = (BIT_W'(b) > span_m1[BIT_W-1:0]);
      end
   end

   assign scan_word = map_rd_data | ((row_ff == last_row) ? tail_mask : '0);

   // Row pattern for initialize: leading reserved bits set, rest clear
   assign init_base = (COUNT_W+1)'({row_ff, {BIT_W{1'b0}}});
   assign init_diff = {1'b0, rsv_ff} - init_base;

   always_comb begin
      init_word = '0;
      if (init_diff[COUNT_W] || (init_diff == '0)) begin
         init_word = '0;
      end else if (init_diff >= (COUNT_W+1)'(WORD_W)) begin
         init_word = '1;
      end else begin
         for (int b = 0; b < WORD_W; b++) begin
            init_word[b] = (BIT_W'(b) < init_diff[BIT_W-1:0]);
         end
      end
   end

   assign req_fire    = req_ch.valid && req_ch.ready;
   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign idx_in_span = (COUNT_W'(req_ch.block_index) < span);

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_index = rsp_data_ff.result_index;
   assign rsp_ch.bit_value    = rsp_data_ff.bit_value;
   assign rsp_ch.free_count   = rsp_data_ff.free_count;
   assign rsp_ch.status       = rsp_data_ff.status;

   always_comb begin
      state_in     = state_ff;
      free_in      = free_ff;
      rsv_in       = rsv_ff;
      idx_in       = idx_ff;
      row_in       = row_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      map_req      = '0;

      // Drop the response once the sink takes it
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in              = req_ch.block_index;
               res_in.result_index = req_ch.block_index;
               res_in.bit_value    = 1'b0;
               res_in.free_count   = free_ff;
               res_in.status       = STS_OK;
               unique case (req_ch.action)
                  ACT_ALLOC: begin
                     if ((free_ff == '0) || (span == '0)) begin
                        res_in.result_index = '0;
                        res_in.status       = STS_NOFREE;
                        state_in            = ST_DONE;
                     end else begin
                        // Start the walk at row 0
                        map_req.rd_en  = 1'b1;
                        map_req.rd_row = '0;
                        row_in         = '0;
                        state_in       = ST_SCAN;
                     end
                  end
                  ACT_FREE: begin
                     if (idx_in_span) begin
                        map_req.rd_en  = 1'b1;
                        map_req.rd_row = row_of(req_ch.block_index);
                        state_in       = ST_FREE;
                     end else begin
                        res_in.status = STS_RANGE;
                        state_in      = ST_DONE;
                     end
                  end
                  ACT_READ: begin
                     if (idx_in_span) begin
                        map_req.rd_en  = 1'b1;
                        map_req.rd_row = row_of(req_ch.block_index);
                        state_in       = ST_READ;
                     end else begin
                        res_in.status = STS_RANGE;
                        state_in      = ST_DONE;
                     end
                  end
                  ACT_INIT: begin
                     // Clamp the reserved count to the span
                     rsv_in   = (rsv_cfg_ff > span) ? span : rsv_cfg_ff;
                     row_in   = '0;
                     state_in = ST_INIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (~scan_word != '0) begin
               // Claim the lowest free bit of this row
               map_req.wr_en       = 1'b1;
               map_req.wr_row      = row_ff;
               map_req.wr_data     = map_rd_data |
                                     (WORD_W'(1) << lowest_zero(scan_word));
               free_in             = free_ff - COUNT_W'(1);
               res_in.free_count   = free_ff - COUNT_W'(1);
               res_in.result_index = INDEX_W'({row_ff, lowest_zero(scan_word)});
               state_in            = ST_DONE;
            end else if (row_ff == last_row) begin
               res_in.result_index = '0;
               res_in.status       = STS_NOFREE;
               state_in            = ST_DONE;
            end else begin
               // Advance to the next row
               map_req.rd_en  = 1'b1;
               map_req.rd_row = row_ff + ROW_W'(1);
               row_in         = row_ff + ROW_W'(1);
            end
         end

         ST_FREE: begin
            map_req.wr_en   = 1'b1;
            map_req.wr_row  = row_of(idx_ff);
            map_req.wr_data = map_rd_data & ~(WORD_W'(1) << bit_of(idx_ff));
            // Saturate rather than wrap on a double free
            if (free_ff != COUNT_MAX) begin
               free_in           = free_ff + COUNT_W'(1);
               res_in.free_count = free_ff + COUNT_W'(1);
            end
            state_in = ST_DONE;
         end

         ST_READ: begin
            res_in.bit_value = map_rd_data[bit_of(idx_ff)];
            state_in         = ST_DONE;
         end

         ST_INIT: begin
            map_req.wr_en   = 1'b1;
            map_req.wr_row  = row_ff;
            map_req.wr_data = init_word;
            if (row_ff == ROW_W'(ROWS - 1)) begin
               free_in           = span - rsv_ff;
               res_in.free_count = span - rsv_ff;
               state_in          = ST_DONE;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end

         ST_DONE: begin
            // Hold the result until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_ff      <= '0;
         total_ff     <= COUNT_W'(4096);
         rsv_cfg_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_TOTAL:    total_ff   <= csr_wr_data;
               CSR_RESERVED: rsv_cfg_ff <= csr_wr_data;
               default:      total_ff   <= total_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsv_ff      <= rsv_in;
      idx_ff      <= idx_in;
      row_ff      <= row_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[sv/bba_map.sv]
// ----------------------------------------------------------------------------
// bba_map
// Bitmap store: one row of bits per memory word, registered read, and a
// valid bit per row so that rows never written since reset read as free.
// ----------------------------------------------------------------------------
module bba_map (
   input  logic                        clock,
   input  logic                        reset,
   input  bba_pkg::map_req_type        map_req,
   output logic [bba_pkg::WORD_W-1:0]  rd_data
);
   import bba_pkg::*;

   logic [WORD_W-1:0] mem_ff [ROWS];
   logic [ROWS-1:0]   row_valid_ff;
   logic [WORD_W-1:0] rd_word_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (map_req.wr_en) begin
         mem_ff[map_req.wr_row] <= map_req.wr_data;
      end
      if (map_req.rd_en) begin
         rd_word_ff <= mem_ff[map_req.rd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (map_req.wr_en) begin
            row_valid_ff[map_req.wr_row] <= 1'b1;
         end
         if (map_req.rd_en) begin
            rd_valid_ff <= row_valid_ff[map_req.rd_row];
         end
      end
   end

   // Drop stale contents of rows untouched since reset
   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule
